// ===== hw/rtl/lpht_pkg.sv =====
// Shared types, constants and helper functions for the linear probe hash table.
`default_nettype none

package lpht_pkg;

  // Default configuration of the table
  localparam int TABLE_SLOTS_DEF = 47;
  localparam int NAME_BYTES_DEF  = 16;

  // Fixed field widths
  localparam int MAX_NAME_BYTES = 16;
  localparam int WORD_W         = 64;
  localparam int NAME_W         = 2 * WORD_W;
  localparam int KEY_W          = 11;
  localparam int SLOT_OUT_W     = 6;
  localparam int PROBE_W        = 6;
  localparam int STATUS_W       = 3;
  localparam int OP_W           = 2;
  localparam int CFG_W          = 6;

  localparam logic [CFG_W-1:0] MAX_PROBES_RST = CFG_W'(10);

  // Request operations (code 3 behaves as a search)
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

  // One table entry as kept in the slot memory
  typedef struct packed {
    logic                used;
    logic [WORD_W-1:0]   name_high;
    logic [WORD_W-1:0]   name_low;
    logic [KEY_W-1:0]    key;
    logic [PROBE_W-1:0]  probes;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Byte mask that keeps the first nb name bytes
  function automatic logic [NAME_W-1:0] name_mask(input int nb);
    logic [NAME_W-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_NAME_BYTES; i++) begin
      if (i < nb) begin
        m[i*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  // Sum of the low 7 bits of every name byte
  function automatic logic [KEY_W-1:0] byte_sum(input logic [NAME_W-1:0] n);
    logic [KEY_W-1:0] s;
    s = '0;
    for (int i = 0; i < MAX_NAME_BYTES; i++) begin
      s = s + KEY_W'(n[i*8 +: 7]);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/linear_probe_hash_table.sv =====
// Top level of the linear probe hash table: request control, probe pipeline, slot memory.
//
// Usage:
//   A request (in_op, in_name_low, in_name_high) transfers at a clock edge with start
//   high and busy low. Ops: insert, search, clear (code 3 acts as a search). Names
//   are up to NAME_BYTES bytes, byte 0 in the low bits; bytes beyond are ignored.
//   Each request gives exactly one result, shown for one cycle with out_strobe high.
//   The receiver cannot stall; busy stays high until the result is out.
//   cfg_we/cfg_wdata write max_search_probes; write it only while busy is low.
// Operation:
//   Insert/search: the key sum and a three-stage mod TABLE_SLOTS unit give the home
//   slot; then the slots are probed, one slot memory read per cycle, pipelined.
//   An insert probes at most TABLE_SLOTS slots.
//   Clear: one memory entry written per cycle, through all TABLE_SLOTS entries.
//   One request at a time; start is taken again in the cycle the result shows.
// Reset:
//   rst_n (synchronous, active low) clears control and starts a clearing pass through
//   all TABLE_SLOTS entries of the slot memory; busy is high during it and no
//   result is produced. max_search_probes returns to 10.
`default_nettype none

module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int NAME_BYTES  = NAME_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [OP_W-1:0]       in_op,
  input  wire logic [WORD_W-1:0]     in_name_low,
  input  wire logic [WORD_W-1:0]     in_name_high,
  // result channel
  output logic                       out_strobe,
  output logic      [STATUS_W-1:0]   out_status,
  output logic      [SLOT_OUT_W-1:0] out_slot,
  output logic      [KEY_W-1:0]      out_key_sum,
  output logic      [PROBE_W-1:0]    out_probe_count,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int D_W    = $clog2(TABLE_SLOTS + 64);
  localparam logic [NAME_W-1:0] NAME_MASK = name_mask(NAME_BYTES);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HASH  = 4'b0010,
    S_PROBE = 4'b0100,
    S_CLEAR = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic              ins_r, ins_nxt;
  logic [WORD_W-1:0] name_lo_r, name_lo_nxt;
  logic [WORD_W-1:0] name_hi_r, name_hi_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [CFG_W-1:0]  max_probes_r;
  logic [D_W-1:0]    lim_r, lim_nxt;
  logic [SLOT_W-1:0] addr_r, addr_nxt;
  logic [D_W-1:0]    dcnt_r, dcnt_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [D_W-1:0]    chk_d_r, chk_d_nxt;
  logic [SLOT_W-1:0] chk_addr_r, chk_addr_nxt;
  logic [SLOT_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              clr_emit_r, clr_emit_nxt;

  logic                  strobe_r, strobe_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [SLOT_OUT_W-1:0] slot_r, slot_nxt;
  logic [KEY_W-1:0]      ksum_r, ksum_nxt;
  logic [PROBE_W-1:0]    probes_r, probes_nxt;

  logic              accept;
  logic [NAME_W-1:0] in_name;
  logic [KEY_W-1:0]  in_key;
  logic              home_start;
  logic              home_done;
  logic [SLOT_W-1:0] home;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  logic              name_eq;
  logic              hit;

  assign accept     = start && !busy;
  assign in_name    = {in_name_high, in_name_low} & NAME_MASK;
  assign in_key     = byte_sum(in_name);
  assign home_start = accept && (in_op != OP_CLEAR);

  // Home slot: key mod TABLE_SLOTS
  lpht_home #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .start (home_start),
    .key   (in_key),
    .done  (home_done),
    .home  (home)
  );

  // Slot memory: used flag, name, key and probe count per slot
  lpht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // Probe evaluation on the entry read last cycle
  assign name_eq = (ram_rdata.name_low == name_lo_r) && (ram_rdata.name_high == name_hi_r);
  assign hit     = chk_vld_r && (ins_r ? !ram_rdata.used : (ram_rdata.used && name_eq));

  // Control: accept, hash wait, pipelined probing, clearing sweep
  always_comb begin
    state_nxt    = state_r;
    ins_nxt      = ins_r;
    name_lo_nxt  = name_lo_r;
    name_hi_nxt  = name_hi_r;
    key_nxt      = key_r;
    lim_nxt      = lim_r;
    addr_nxt     = addr_r;
    dcnt_nxt     = dcnt_r;
    chk_vld_nxt  = 1'b0;
    chk_d_nxt    = chk_d_r;
    chk_addr_nxt = chk_addr_r;
    clr_addr_nxt = clr_addr_r;
    clr_emit_nxt = clr_emit_r;
    strobe_nxt   = 1'b0;
    status_nxt   = status_r;
    slot_nxt     = slot_r;
    ksum_nxt     = ksum_r;
    probes_nxt   = probes_r;
    ram_we       = 1'b0;
    ram_waddr    = clr_addr_r;
    ram_wdata    = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ins_nxt     = (in_op == OP_INSERT);
          name_lo_nxt = in_name[WORD_W-1:0];
          name_hi_nxt = in_name[NAME_W-1:WORD_W];
          key_nxt     = in_key;
          if (in_op == OP_CLEAR) begin
            clr_addr_nxt = '0;
            clr_emit_nxt = 1'b1;
            state_nxt    = S_CLEAR;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end

      S_HASH: begin
        if (home_done) begin
          addr_nxt  = home;
          dcnt_nxt  = '0;
          lim_nxt   = ins_r ? D_W'(TABLE_SLOTS - 1) : D_W'(max_probes_r);
          state_nxt = S_PROBE;
        end
      end

      S_PROBE: begin
        // issue the next read while checking the previous one
        if (dcnt_r <= lim_r) begin
          chk_vld_nxt  = 1'b1;
          chk_d_nxt    = dcnt_r;
          chk_addr_nxt = addr_r;
          dcnt_nxt     = dcnt_r + 1'b1;
          addr_nxt     = (addr_r == LAST_SLOT) ? '0 : addr_r + 1'b1;
        end
        if (hit) begin
          strobe_nxt = 1'b1;
          slot_nxt   = SLOT_OUT_W'(chk_addr_r);
          state_nxt  = S_IDLE;
          if (ins_r) begin
            ram_we              = 1'b1;
            ram_waddr           = chk_addr_r;
            ram_wdata.used      = 1'b1;
            ram_wdata.name_low  = name_lo_r;
            ram_wdata.name_high = name_hi_r;
            ram_wdata.key       = key_r;
            ram_wdata.probes    = PROBE_W'(chk_d_r + 1'b1);
            status_nxt          = ST_INSERTED;
            ksum_nxt            = key_r;
            probes_nxt          = PROBE_W'(chk_d_r + 1'b1);
          end else begin
            status_nxt = ST_FOUND;
            ksum_nxt   = ram_rdata.key;
            probes_nxt = ram_rdata.probes;
          end
        end else if (chk_vld_r && (chk_d_r == lim_r)) begin
          strobe_nxt = 1'b1;
          status_nxt = ins_r ? ST_FULL : ST_MISSING;
          slot_nxt   = '0;
          ksum_nxt   = key_r;
          probes_nxt = '0;
          state_nxt  = S_IDLE;
        end
      end

      S_CLEAR: begin
        // one entry per cycle written as free
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
          if (clr_emit_r) begin
            strobe_nxt = 1'b1;
            status_nxt = ST_CLEARED;
            slot_nxt   = '0;
            ksum_nxt   = '0;
            probes_nxt = '0;
          end
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      clr_emit_r   <= 1'b0;
      chk_vld_r    <= 1'b0;
      dcnt_r       <= '0;
      strobe_r     <= 1'b0;
      max_probes_r <= MAX_PROBES_RST;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      clr_emit_r <= clr_emit_nxt;
      chk_vld_r  <= chk_vld_nxt;
      dcnt_r     <= dcnt_nxt;
      strobe_r   <= strobe_nxt;
      if (cfg_we) begin
        max_probes_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ins_r      <= ins_nxt;
    name_lo_r  <= name_lo_nxt;
    name_hi_r  <= name_hi_nxt;
    key_r      <= key_nxt;
    lim_r      <= lim_nxt;
    addr_r     <= addr_nxt;
    chk_d_r    <= chk_d_nxt;
    chk_addr_r <= chk_addr_nxt;
    status_r   <= status_nxt;
    slot_r     <= slot_nxt;
    ksum_r     <= ksum_nxt;
    probes_r   <= probes_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_slot        = slot_r;
  assign out_key_sum     = ksum_r;
  assign out_probe_count = probes_r;

endmodule

`default_nettype wire

// ===== hw/rtl/lpht_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lpht_home.sv =====
// Key mod TABLE_SLOTS unit: reciprocal multiplication over three register stages.
`default_nettype none

module lpht_home
  import lpht_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [KEY_W-1:0]               key,
  output logic                                done,
  output logic      [$clog2(TABLE_SLOTS)-1:0] home
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int REC_W  = KEY_W + 1;
  localparam int PROD_W = KEY_W + REC_W;
  // floor(key * RECIP / 2**SHIFT) equals floor(key / TABLE_SLOTS) for every key
  localparam int SHIFT  = KEY_W + $clog2(TABLE_SLOTS);
  localparam logic [REC_W-1:0] RECIP =
    REC_W'(((2 ** SHIFT) + TABLE_SLOTS - 1) / TABLE_SLOTS);
  localparam logic [KEY_W-1:0] SLOTS_K = KEY_W'(TABLE_SLOTS);

  logic [KEY_W-1:0]  key_r;
  logic [KEY_W-1:0]  quot_r, quot_nxt;
  logic [KEY_W-1:0]  rem_r, rem_nxt;
  logic [PROD_W-1:0] prod;
  logic              stg0_r;
  logic              stg1_r;
  logic              done_r;

  // Quotient by reciprocal multiplication
  assign prod     = {{REC_W{1'b0}}, key_r} * {{KEY_W{1'b0}}, RECIP};
  assign quot_nxt = KEY_W'(prod >> SHIFT);

  // Remainder: key less quotient times the slot count
  assign rem_nxt = key_r - quot_r * SLOTS_K;

  // Stage valid chain: key, quotient, remainder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg0_r <= 1'b0;
      stg1_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      stg0_r <= start;
      stg1_r <= stg0_r;
      done_r <= stg1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= key;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign home = rem_r[SLOT_W-1:0];

endmodule

`default_nettype wire
